### hdl/crc8_frame_receiver_assert.svh
// Assertion helpers shared by the frame receiver RTL.
`ifndef CRC8_FRAME_RECEIVER_ASSERT_SVH
`define CRC8_FRAME_RECEIVER_ASSERT_SVH

// Generic form: explicit clock and active-low reset.
`define CRC8FR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Common form: the block's own clk_i / rst_ni.
`define CRC8FR_ASSERT(lbl, prop, msg) \
  `CRC8FR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### hdl/crc8fr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crc8fr_pkg;

  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned OUT_CNT_W  = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0] CRC_POLY     = 8'h07;
  localparam logic [7:0] CRC_MSB_MASK = 8'h80;

  localparam logic [7:0] START_BYTE_RST  = 8'd170;
  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd251;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE  = 2'd0,
    CFG_MAX_PAYLOAD = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_DATA   = 3'd1,
    EV_GOOD   = 3'd2,
    EV_BADCRC = 3'd3,
    EV_REJECT = 3'd4
  } event_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] max_payload_len;
  } cfg_t;

  typedef struct packed {
    event_e                 event_res;
    logic [7:0]             payload_byte;
    logic [7:0]             payload_index;
    logic [7:0]             frame_type;
    logic [7:0]             frame_length;
    logic [OUT_CNT_W-1:0]   good_frames;
    logic [OUT_CNT_W-1:0]   bad_crc_frames;
  } res_t;

  // CRC-8, poly 0x07, MSB first, one byte per call.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB_MASK) != 8'd0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hdl/crc8fr_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Received byte channel.
interface crc8fr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel, one result per received byte.
interface crc8fr_res_if;
  logic                             valid;
  logic                             ready;
  logic [2:0]                       event_res;
  logic [7:0]                       payload_byte;
  logic [7:0]                       payload_index;
  logic [7:0]                       frame_type;
  logic [7:0]                       frame_length;
  logic [crc8fr_pkg::OUT_CNT_W-1:0] good_frames;
  logic [crc8fr_pkg::OUT_CNT_W-1:0] bad_crc_frames;

  modport source (output valid, output event_res, output payload_byte,
                  output payload_index, output frame_type, output frame_length,
                  output good_frames, output bad_crc_frames, input ready);
  modport sink   (input valid, input event_res, input payload_byte,
                  input payload_index, input frame_type, input frame_length,
                  input good_frames, input bad_crc_frames, output ready);
endinterface

`default_nettype wire

### hdl/crc8fr_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module crc8fr_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [crc8fr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [crc8fr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output crc8fr_pkg::cfg_t                       cfg_o
);

  crc8fr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte      <= crc8fr_pkg::START_BYTE_RST;
      cfg_q.max_payload_len <= crc8fr_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      // Indices past the list are dropped.
      unique case (cfg_idx_i)
        crc8fr_pkg::CFG_START_BYTE:  cfg_q.start_byte      <= cfg_wdata_i[7:0];
        crc8fr_pkg::CFG_MAX_PAYLOAD: cfg_q.max_payload_len <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hdl/crc8fr_parser.sv
`timescale 1ns / 1ps
`default_nettype none

`include "crc8_frame_receiver_assert.svh"

module crc8fr_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire crc8fr_pkg::cfg_t cfg_i,
  input  wire logic       byte_valid_i,
  input  wire logic [7:0] byte_i,
  output logic            byte_take_o,
  output logic            res_valid_o,
  input  wire logic       res_ready_i,
  output crc8fr_pkg::res_t res_o
);

  localparam int unsigned CntW = crc8fr_pkg::COUNT_BITS;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_TYPE    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [7:0]        len_q, len_d;
  logic [7:0]        type_q, type_d;
  logic [7:0]        seen_q, seen_d;
  logic [7:0]        crc_q, crc_d;
  logic [CntW-1:0]   good_q, good_d;
  logic [CntW-1:0]   bad_q, bad_d;
  logic              res_valid_q;
  crc8fr_pkg::res_t  res_q, res_d;
  crc8fr_pkg::event_e ev;
  logic [7:0]        pbyte, pidx, crc_next;
  logic              take;

  // Result slot is free, or is being drained this cycle.
  assign take        = byte_valid_i && (!res_valid_q || res_ready_i);
  assign byte_take_o = take;
  assign crc_next    = crc8fr_pkg::crc8_update(crc_q, byte_i);

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    type_d  = type_q;
    seen_d  = seen_q;
    crc_d   = crc_q;
    good_d  = good_q;
    bad_d   = bad_q;
    ev      = crc8fr_pkg::EV_NONE;
    pbyte   = 8'd0;
    pidx    = 8'd0;
    unique case (phase_q)
      PH_LEN: begin
        len_d = byte_i;
        if (byte_i > cfg_i.max_payload_len) begin
          ev      = crc8fr_pkg::EV_REJECT;
          phase_d = PH_HUNT;
        end else begin
          crc_d   = crc_next;
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_d  = byte_i;
        seen_d  = 8'd0;
        crc_d   = crc_next;
        phase_d = (len_q == 8'd0) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        ev     = crc8fr_pkg::EV_DATA;
        pbyte  = byte_i;
        pidx   = seen_q;
        crc_d  = crc_next;
        seen_d = seen_q + 8'd1;
        if (seen_d >= len_q) begin
          phase_d = PH_CRC;
        end
      end
      PH_CRC: begin
        if (crc_q == byte_i) begin
          ev     = crc8fr_pkg::EV_GOOD;
          good_d = good_q + {{(CntW-1){1'b0}}, 1'b1};
        end else begin
          ev    = crc8fr_pkg::EV_BADCRC;
          bad_d = bad_q + {{(CntW-1){1'b0}}, 1'b1};
        end
        phase_d = PH_HUNT;
      end
      default: begin
        // hunt: a start byte opens a frame and clears the frame state
        if (byte_i == cfg_i.start_byte) begin
          len_d   = 8'd0;
          type_d  = 8'd0;
          seen_d  = 8'd0;
          crc_d   = 8'd0;
          phase_d = PH_LEN;
        end else begin
          phase_d = PH_HUNT;
        end
      end
    endcase

    res_d.event_res      = ev;
    res_d.payload_byte   = pbyte;
    res_d.payload_index  = pidx;
    res_d.frame_type     = type_d;
    res_d.frame_length   = len_d;
    res_d.good_frames    = crc8fr_pkg::OUT_CNT_W'(good_d);
    res_d.bad_crc_frames = crc8fr_pkg::OUT_CNT_W'(bad_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      len_q       <= 8'd0;
      type_q      <= 8'd0;
      seen_q      <= 8'd0;
      crc_q       <= 8'd0;
      good_q      <= '0;
      bad_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q     <= phase_d;
        len_q       <= len_d;
        type_q      <= type_d;
        seen_q      <= seen_d;
        crc_q       <= crc_d;
        good_q      <= good_d;
        bad_q       <= bad_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `CRC8FR_ASSERT(a_payload_in_bounds,
    (phase_q == PH_PAYLOAD) |-> (seen_q < len_q),
    "payload count reached length inside payload phase")
  `CRC8FR_ASSERT(a_data_index_ok,
    (res_valid_q && res_q.event_res == crc8fr_pkg::EV_DATA)
      |-> (res_q.payload_index < res_q.frame_length),
    "payload index beyond frame length")
  `CRC8FR_ASSERT(a_good_only_on_verdict,
    !(take && ev == crc8fr_pkg::EV_GOOD) |=> $stable(good_q),
    "good counter moved without a good verdict")
  `CRC8FR_ASSERT(a_bad_only_on_verdict,
    !(take && ev == crc8fr_pkg::EV_BADCRC) |=> $stable(bad_q),
    "crc error counter moved without a crc error")

endmodule

`default_nettype wire

### hdl/crc8_frame_receiver.sv
// crc8_frame_receiver: SOF / length / type / payload / CRC-8 frame parser.
// Channels: rx_i takes one received byte per transfer (valid/ready);
//   res_o returns exactly one result per byte, in order: an event code
//   (none, payload byte, frame good, crc error, length rejected), the
//   payload byte and its index, the current type and length, and the
//   good / bad-crc frame counters.
// Config: cfg_we_i/cfg_idx_i/cfg_wdata_i write start_byte (0) or
//   max_payload_len (1); other indices are ignored. Write while idle.
// Path: each byte passes the input register, then the parse logic into
//   the result register.
// Throughput: one byte per cycle while res_o.ready is high; the CRC-8
//   byte update and the phase decode fit in the single stage between
//   the two registers.
// Stall: rx_i.ready drops only when both the input register and the
//   result register are full and res_o.ready is low; nothing is lost.
// Reset (rst_ni, async low): parser hunts for a start byte, frame state
//   and counters are zero, start_byte = 0xAA, max_payload_len = 251.
`timescale 1ns / 1ps
`default_nettype none

`include "crc8_frame_receiver_assert.svh"

module crc8_frame_receiver (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [crc8fr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [crc8fr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  crc8fr_byte_if.sink                            rx_i,
  crc8fr_res_if.source                           res_o
);

  crc8fr_pkg::cfg_t cfg;
  crc8fr_pkg::res_t res;
  logic             s1_valid_q;
  logic [7:0]       s1_byte_q;
  logic             byte_take;
  logic             res_valid;
  logic             rx_xfer;

  crc8fr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register: refills in the same cycle the parser takes its byte.
  assign rx_i.ready = !s1_valid_q || byte_take;
  assign rx_xfer    = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      if (rx_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (byte_take) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_xfer) begin
      s1_byte_q <= rx_i.rx_byte;
    end
  end

  crc8fr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .byte_valid_i (s1_valid_q),
    .byte_i       (s1_byte_q),
    .byte_take_o  (byte_take),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_o.ready),
    .res_o        (res)
  );

  assign res_o.valid          = res_valid;
  assign res_o.event_res      = res.event_res;
  assign res_o.payload_byte   = res.payload_byte;
  assign res_o.payload_index  = res.payload_index;
  assign res_o.frame_type     = res.frame_type;
  assign res_o.frame_length   = res.frame_length;
  assign res_o.good_frames    = res.good_frames;
  assign res_o.bad_crc_frames = res.bad_crc_frames;

  // An empty result register must never hold off the input side.
  `CRC8FR_ASSERT(a_ready_when_res_empty,
    !res_valid |-> rx_i.ready,
    "input stalled with empty result register")
  // A buffered byte always moves on once the result side drains.
  `CRC8FR_ASSERT(a_take_on_drain,
    (s1_valid_q && res_o.ready) |-> byte_take,
    "buffered byte not taken while output drains")

endmodule

`default_nettype wire
